/* rtl/aabb_frustum_plane_test_core_defines.svh */
// Assertion macros shared by the culling core RTL.
// Both macros expect clk and arst_n in scope.
`ifndef AABB_FRUSTUM_PLANE_TEST_CORE_DEFINES_SVH
`define AABB_FRUSTUM_PLANE_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define AFPT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AFPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/afpt_pkg.sv */
`timescale 1ns / 1ps

package afpt_pkg;

	// Default configuration
	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_BITS_DEF  = 16;

	// Fixed field widths
	localparam int NORM_BITS      = 16;
	localparam int D_FRAC_SHIFT   = 13;   // Q12.4 offset to Q*.17 product scale
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int M_DATA_BITS    = 8;

	// Operation codes (tuser)
	localparam logic OP_FRUSTUM  = 1'b0;
	localparam logic OP_STRADDLE = 1'b1;

	// One plane register: nx in the low bits, d in the top bits
	typedef struct packed {
		logic signed [NORM_BITS-1:0] d;
		logic signed [NORM_BITS-1:0] nz;
		logic signed [NORM_BITS-1:0] ny;
		logic signed [NORM_BITS-1:0] nx;
	} plane_t;

	// Load enables of the pipeline stages a plane lane owns
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

/* rtl/afpt_plane_lane.sv */
`timescale 1ns / 1ps

module afpt_plane_lane
	import afpt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ACC_W      = 36
) (
	input  logic                         clk,
	input  stage_en_t                    en,
	input  plane_t                       plane,
	input  logic signed [COORD_BITS-1:0] bmin [3],
	input  logic signed [COORD_BITS-1:0] bmax [3],
	output logic                         neg
);

	localparam int PROD_W = NORM_BITS + COORD_BITS;

	logic signed [NORM_BITS-1:0]  n      [3];
	logic signed [COORD_BITS-1:0] corner [3];
	logic signed [PROD_W-1:0]     prod_s2 [3];
	logic signed [NORM_BITS-1:0]  d_s2;
	logic signed [ACC_W-1:0]      acc;
	logic                         neg_s3;

	assign n[0] = plane.nx;
	assign n[1] = plane.ny;
	assign n[2] = plane.nz;

	// Far corner per axis: max on a positive normal, min otherwise
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			corner[a] = (n[a] > 0) ? bmax[a] : bmin[a];
		end
	end

	// Stage 2: one product per axis
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int a = 0; a < 3; a++) begin
				prod_s2[a] <= n[a] * corner[a];
			end
			d_s2 <= plane.d;
		end
	end

	// Stage 3: signed distance, keep only its sign
	assign acc = (ACC_W'(d_s2) <<< D_FRAC_SHIFT) + ACC_W'(prod_s2[0])
		+ ACC_W'(prod_s2[1]) + ACC_W'(prod_s2[2]);

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			neg_s3 <= acc[ACC_W-1];
		end
	end

	assign neg = neg_s3;

endmodule

/* rtl/aabb_frustum_plane_test_core.sv */
// Box culling core: one axis-aligned box per input word, one hit flag per output
// word. tuser selects the test: frustum (box not wholly outside any configured
// plane) or straddle (box touches the plane given in the word). The pipeline has
// four register stages, and a new word is taken every cycle while m_tready keeps
// the output moving; stage 2 forms one 16 x COORD_BITS product per axis per
// plane lane. The user writes planes through the cfg port only while no word is
// in flight (the core does not enforce this); all planes reset to zero.
`timescale 1ns / 1ps

`include "aabb_frustum_plane_test_core_defines.svh"

module aabb_frustum_plane_test_core
	import afpt_pkg::*;
#(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	localparam int S_DATA_BITS = ((6 * COORD_BITS + 4 * NORM_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,

	input  logic                      s_tvalid,
	output logic                      s_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
	// test_normal_x, test_normal_y, test_normal_z, test_offset, zero pad
	input  logic [S_DATA_BITS-1:0]    s_tdata,
	// op
	input  logic [0:0]                s_tuser,

	output logic                      m_tvalid,
	input  logic                      m_tready,
	// hit, zero pad
	output logic [M_DATA_BITS-1:0]    m_tdata
);

	localparam int SUM_W   = COORD_BITS + 1;
	localparam int PROD_W  = NORM_BITS + SUM_W;
	localparam int DTERM_W = NORM_BITS + D_FRAC_SHIFT + 1;
	localparam int ACC_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 3;
	localparam int TEST_LSB = 6 * COORD_BITS;

	// Plane registers
	plane_t plane_q [PLANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				plane_q[p] <= '0;
			end
		end else if (cfg_we) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				if (cfg_index == CFG_INDEX_BITS'(p)) begin
					plane_q[p] <= plane_t'(cfg_data);
				end
			end
		end
	end

	// Stage enables: a stage loads when empty or when the next one moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	stage_en_t lane_en;

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign lane_en  = '{en_s2: en_s2, en_s3: en_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Unpack the input word
	logic signed [COORD_BITS-1:0] in_min  [3];
	logic signed [COORD_BITS-1:0] in_max  [3];
	logic signed [NORM_BITS-1:0]  in_norm [3];
	logic signed [NORM_BITS-1:0]  in_offset;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			in_min[a]  = s_tdata[a * COORD_BITS +: COORD_BITS];
			in_max[a]  = s_tdata[(a + 3) * COORD_BITS +: COORD_BITS];
			in_norm[a] = s_tdata[TEST_LSB + a * NORM_BITS +: NORM_BITS];
		end
		in_offset = s_tdata[TEST_LSB + 3 * NORM_BITS +: NORM_BITS];
	end

	// Stage 1: register the box, plus center and extent sums for straddle
	logic                         op_s1;
	logic signed [COORD_BITS-1:0] bmin_s1 [3];
	logic signed [COORD_BITS-1:0] bmax_s1 [3];
	logic signed [SUM_W-1:0]      sum_s1  [3];
	logic signed [SUM_W-1:0]      diff_s1 [3];
	logic signed [NORM_BITS-1:0]  tn_s1   [3];
	logic signed [NORM_BITS-1:0]  td_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= s_tuser[0];
			for (int a = 0; a < 3; a++) begin
				bmin_s1[a] <= in_min[a];
				bmax_s1[a] <= in_max[a];
				sum_s1[a]  <= SUM_W'(in_max[a]) + SUM_W'(in_min[a]);
				diff_s1[a] <= SUM_W'(in_max[a]) - SUM_W'(in_min[a]);
				tn_s1[a]   <= in_norm[a];
			end
			td_s1 <= in_offset;
		end
	end

	// Frustum lanes, stages 2 and 3
	logic [PLANE_COUNT-1:0] neg_s3;

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		afpt_plane_lane #(
			.COORD_BITS(COORD_BITS),
			.ACC_W     (ACC_W)
		) u_lane (
			.clk  (clk),
			.en   (lane_en),
			.plane(plane_q[p]),
			.bmin (bmin_s1),
			.bmax (bmax_s1),
			.neg  (neg_s3[p])
		);
	end

	// Stage 2: straddle products
	logic                        op_s2;
	logic signed [PROD_W-1:0]    pdist_s2 [3];
	logic signed [PROD_W-1:0]    prad_s2  [3];
	logic signed [NORM_BITS-1:0] td_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2 <= op_s1;
			for (int a = 0; a < 3; a++) begin
				pdist_s2[a] <= tn_s1[a] * sum_s1[a];
				prad_s2[a]  <= tn_s1[a] * diff_s1[a];
			end
			td_s2 <= td_s1;
		end
	end

	// Stage 3: doubled center distance and radius
	logic signed [ACC_W-1:0] rad_ext [3];
	logic signed [ACC_W-1:0] rad_abs [3];
	logic signed [ACC_W-1:0] dist_c, rad_c;
	logic                    op_s3;
	logic signed [ACC_W-1:0] dist_s3, rad_s3;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rad_ext[a] = ACC_W'(prad_s2[a]);
			rad_abs[a] = rad_ext[a][ACC_W-1] ? -rad_ext[a] : rad_ext[a];
		end
		dist_c = ACC_W'(pdist_s2[0]) + ACC_W'(pdist_s2[1]) + ACC_W'(pdist_s2[2])
			- (ACC_W'(td_s2) <<< (D_FRAC_SHIFT + 1));
		rad_c = rad_abs[0] + rad_abs[1] + rad_abs[2];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3   <= op_s2;
			dist_s3 <= dist_c;
			rad_s3  <= rad_c;
		end
	end

	// Stage 4: pick the flag for the operation; output register
	logic signed [ACC_W-1:0] dist_abs;
	logic                    hit_c;
	logic                    hit_s4;

	always_comb begin
		dist_abs = dist_s3[ACC_W-1] ? -dist_s3 : dist_s3;
		case (op_s3)
			OP_STRADDLE: hit_c = (dist_abs <= rad_s3);
			default:     hit_c = !(|neg_s3);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hit_s4 <= hit_c;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {{(M_DATA_BITS - 1){1'b0}}, hit_s4};

	// Checks
	`AFPT_ASSERT(a_ready_only_full, !s_tready, v_s1 && v_s2 && v_s3 && v_s4 && !m_tready, "input stalled with a free stage")
	`AFPT_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, v_s1, "accepted word missing from stage 1")
	`AFPT_ASSERT_NEXT(a_s3_hold, v_s3 && !en_s4, v_s3 && v_s4, "stalled stage 3 word lost")
	`AFPT_ASSERT(a_rad_nonneg, v_s3 && op_s3 == OP_STRADDLE, !rad_s3[ACC_W-1], "straddle radius overflow")

endmodule
